// ----- hdl/ssd_pkg.sv -----
// shared types, command constants and digit helpers for the display frame builder
// no dependencies; used by ssd_digit_pipe, ssd_frame_ser and the top level
`default_nettype none

package ssd_pkg;

  localparam logic       OP_SHOW      = 1'b0;
  localparam logic       OP_BRIGHT    = 1'b1;

  localparam logic [7:0] CMD_DATA     = 8'h40;
  localparam logic [7:0] CMD_ADDR     = 8'hC0;
  localparam logic [7:0] CMD_BRIGHT   = 8'h87;
  localparam logic [3:0] BRIGHT_MAX   = 4'd8;
  localparam logic [3:0] BRIGHT_RESET = 4'd8;
  localparam logic [7:0] SEP_BIT      = 8'h80;

  // x / 10 == (x * 0xcccd) >> 19 for every 16-bit x
  localparam logic [15:0] DIV10_MUL   = 16'hCCCD;

  // byte slots of a show sequence, in send order
  typedef enum logic [2:0] {
    SLOT_DATA,
    SLOT_ADDR,
    SLOT_THOU,
    SLOT_HUND,
    SLOT_TENS,
    SLOT_ONES
  } slot_t;

  // one decoded request leaving the digit pipeline
  typedef struct packed {
    logic       op;
    logic [7:0] thou;
    logic [7:0] hund;
    logic [7:0] tens;
    logic [7:0] ones;
  } item_t;

  // segment pattern, bit 0 = a ... bit 6 = g
  function automatic logic [7:0] seg_of(input logic [3:0] d);
    logic [7:0] s;
    case (d)
      4'd0:    s = 8'h3f;
      4'd1:    s = 8'h06;
      4'd2:    s = 8'h5b;
      4'd3:    s = 8'h4f;
      4'd4:    s = 8'h66;
      4'd5:    s = 8'h6d;
      4'd6:    s = 8'h7d;
      4'd7:    s = 8'h07;
      4'd8:    s = 8'h7f;
      4'd9:    s = 8'h6f;
      default: s = 8'h00;
    endcase
    return s;
  endfunction

  // x - 10*q, where q = x / 10; only the low nibbles matter
  function automatic logic [3:0] rem10(input logic [3:0] x_lo, input logic [3:0] q_lo);
    logic [3:0] q2;
    logic [3:0] q8;
    q2 = {q_lo[2:0], 1'b0};
    q8 = {q_lo[0], 3'b000};
    return 4'(x_lo - q2 - q8);
  endfunction

  // x mod 10 for a 7-bit value by conditional subtraction
  function automatic logic [3:0] mod10_small(input logic [6:0] x);
    logic [6:0] r;
    r = x;
    if (r >= 7'd80) r = 7'(r - 7'd80);
    if (r >= 7'd40) r = 7'(r - 7'd40);
    if (r >= 7'd20) r = 7'(r - 7'd20);
    if (r >= 7'd10) r = 7'(r - 7'd10);
    return r[3:0];
  endfunction

endpackage

`default_nettype wire

// ----- hdl/ssd_digit_pipe.sv -----
// four-stage pipeline splitting a 16-bit value into four decimal digits
// and mapping them to segment bytes; depends on ssd_pkg
`default_nettype none

module ssd_digit_pipe (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           en,
  input  wire logic           in_valid,
  input  wire logic           in_operation,
  input  wire logic [15:0]    in_value,
  input  wire logic           in_separator,
  output      logic           item_valid,
  output      ssd_pkg::item_t item
);

  // stage 1: value / 10
  logic        v1_r;
  logic        op1_r, sep1_r;
  logic [3:0]  x0_lo1_r;
  logic [12:0] q1_r;
  // stage 2: ones digit, q1 / 10
  logic        v2_r;
  logic        op2_r, sep2_r;
  logic [3:0]  d0_2_r;
  logic [3:0]  q1_lo2_r;
  logic [9:0]  q2_r;
  // stage 3: tens digit, q2 / 10
  logic        v3_r;
  logic        op3_r, sep3_r;
  logic [3:0]  d0_3_r, d1_3_r;
  logic [3:0]  q2_lo3_r;
  logic [6:0]  q3_r;
  // stage 4: hundreds and thousands digits, segment bytes
  logic        v4_r;
  ssd_pkg::item_t item4_r;

  logic [31:0] p1;
  logic [28:0] p2;
  logic [25:0] p3;
  logic [3:0]  d2, d3;
  logic [7:0]  hund_seg;

  assign p1 = 32'(in_value) * 32'(ssd_pkg::DIV10_MUL);
  assign p2 = 29'(q1_r) * 29'(ssd_pkg::DIV10_MUL);
  assign p3 = 26'(q2_r) * 26'(ssd_pkg::DIV10_MUL);
  assign d2 = ssd_pkg::rem10(q2_lo3_r, q3_r[3:0]);
  assign d3 = ssd_pkg::mod10_small(q3_r);
  assign hund_seg = ssd_pkg::seg_of(d2) | (sep3_r ? ssd_pkg::SEP_BIT : 8'h00);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
    end else if (en) begin
      v1_r <= in_valid;
      v2_r <= v1_r;
      v3_r <= v2_r;
      v4_r <= v3_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      op1_r    <= in_operation;
      sep1_r   <= in_separator;
      x0_lo1_r <= in_value[3:0];
      q1_r     <= p1[31:19];

      op2_r    <= op1_r;
      sep2_r   <= sep1_r;
      d0_2_r   <= ssd_pkg::rem10(x0_lo1_r, q1_r[3:0]);
      q1_lo2_r <= q1_r[3:0];
      q2_r     <= p2[28:19];

      op3_r    <= op2_r;
      sep3_r   <= sep2_r;
      d0_3_r   <= d0_2_r;
      d1_3_r   <= ssd_pkg::rem10(q1_lo2_r, q2_r[3:0]);
      q2_lo3_r <= q2_r[3:0];
      q3_r     <= p3[25:19];

      item4_r.op   <= op3_r;
      item4_r.thou <= ssd_pkg::seg_of(d3);
      item4_r.hund <= hund_seg;
      item4_r.tens <= ssd_pkg::seg_of(d1_3_r);
      item4_r.ones <= ssd_pkg::seg_of(d0_3_r);
    end
  end

  assign item_valid = v4_r;
  assign item       = item4_r;

endmodule

`default_nettype wire

// ----- hdl/ssd_frame_ser.sv -----
// output register and byte sequencer: one framed byte per accepted word
// depends on ssd_pkg
`default_nettype none

module ssd_frame_ser (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           item_valid,
  input  wire ssd_pkg::item_t item,
  output      logic           take,
  input  wire logic [3:0]     brightness,
  output      logic           out_valid,
  input  wire logic           out_ready,
  output      logic [7:0]     out_frame_byte,
  output      logic           out_start_before,
  output      logic           out_stop_after,
  output      logic           out_last
);

  logic           busy_r;
  ssd_pkg::slot_t slot_r;
  ssd_pkg::item_t hold_r;

  logic           is_last;
  logic [3:0]     bright_sat;

  assign is_last    = (hold_r.op == ssd_pkg::OP_BRIGHT) || (slot_r == ssd_pkg::SLOT_ONES);
  assign take       = !busy_r || (out_ready && is_last);
  assign bright_sat = (brightness > ssd_pkg::BRIGHT_MAX) ? ssd_pkg::BRIGHT_MAX : brightness;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      slot_r <= ssd_pkg::SLOT_DATA;
    end else if (take) begin
      busy_r <= item_valid;
      slot_r <= ssd_pkg::SLOT_DATA;
    end else if (out_ready) begin
      slot_r <= ssd_pkg::slot_t'(3'(slot_r + 3'd1));
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      hold_r <= item;
    end
  end

  always_comb begin
    out_frame_byte   = 8'h00;
    out_start_before = 1'b0;
    out_stop_after   = 1'b0;
    if (hold_r.op == ssd_pkg::OP_BRIGHT) begin
      out_frame_byte   = 8'(ssd_pkg::CMD_BRIGHT + 8'(bright_sat));
      out_start_before = 1'b1;
      out_stop_after   = 1'b1;
    end else begin
      unique case (slot_r)
        ssd_pkg::SLOT_DATA: begin
          out_frame_byte   = ssd_pkg::CMD_DATA;
          out_start_before = 1'b1;
          out_stop_after   = 1'b1;
        end
        ssd_pkg::SLOT_ADDR: begin
          out_frame_byte   = ssd_pkg::CMD_ADDR;
          out_start_before = 1'b1;
        end
        ssd_pkg::SLOT_THOU: out_frame_byte = hold_r.thou;
        ssd_pkg::SLOT_HUND: out_frame_byte = hold_r.hund;
        ssd_pkg::SLOT_TENS: out_frame_byte = hold_r.tens;
        ssd_pkg::SLOT_ONES: begin
          out_frame_byte = hold_r.ones;
          out_stop_after = 1'b1;
        end
        default: out_frame_byte = 8'h00;
      endcase
    end
  end

  assign out_valid = busy_r;
  assign out_last  = is_last;

`ifndef SYNTHESIS
  a_slot_range: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r |-> (slot_r <= ssd_pkg::SLOT_ONES))
    else $error("slot counter out of range");

  a_bright_single: assert property (@(posedge clk) disable iff (!rst_n)
    (busy_r && hold_r.op == ssd_pkg::OP_BRIGHT) |-> (slot_r == ssd_pkg::SLOT_DATA))
    else $error("brightness word past first slot");

  a_slot_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (busy_r && !out_ready) |=> ($stable(slot_r) && busy_r))
    else $error("slot moved while receiver stalled");

  a_seq_continue: assert property (@(posedge clk) disable iff (!rst_n)
    (busy_r && out_ready && !is_last) |=> (busy_r && slot_r != ssd_pkg::SLOT_DATA))
    else $error("show sequence broken off early");
`endif

endmodule

`default_nettype wire

// ----- hdl/seven_segment_display_frame_builder_core.sv -----
// Frame builder for a four-digit seven-segment display controller.
// Input channel (in_valid/in_ready): one request word. in_operation selects
// show (0) or brightness (1); in_value is shown as its low four decimal
// digits, in_separator lights bit 7 of the hundreds digit.
// Output channel (out_valid/out_ready): one framed byte per word, with
// out_start_before, out_stop_after and out_last marking frame edges and the
// final byte of a request. A show request gives six bytes, a brightness
// request one.
// Config channel (cfg_valid/cfg_ready): writes the 4-bit brightness, always
// ready; values above 8 are sent as 8. Write only while the block is idle.
// The first byte becomes valid once the request has passed the four digit
// stages and the output register (the accepting edge loads the first digit
// stage, then the three further stages and the output register load in turn).
// Throughput is set by the output sequencer: one byte per cycle while
// out_ready is high; requests follow each other with no gap.
// Reset (synchronous, rst_n low) empties the pipeline and output register
// and sets brightness to 8. When out_ready is low the current byte holds;
// once the last digit stage waits too, the whole pipeline holds and in_ready
// drops; nothing is lost or repeated.
// Depends on ssd_pkg, ssd_digit_pipe, ssd_frame_ser.
`default_nettype none

module seven_segment_display_frame_builder_core (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output      logic        in_ready,
  input  wire logic        in_operation,
  input  wire logic [15:0] in_value,
  input  wire logic        in_separator,
  output      logic        out_valid,
  input  wire logic        out_ready,
  output      logic [7:0]  out_frame_byte,
  output      logic        out_start_before,
  output      logic        out_stop_after,
  output      logic        out_last,
  input  wire logic        cfg_valid,
  output      logic        cfg_ready,
  input  wire logic [3:0]  cfg_brightness
);

  logic [3:0]     brightness_r;
  logic           item_valid;
  ssd_pkg::item_t item;
  logic           take;
  logic           en;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      brightness_r <= ssd_pkg::BRIGHT_RESET;
    end else if (cfg_valid) begin
      brightness_r <= cfg_brightness;
    end
  end

  // pipeline moves as a whole unless its last stage is blocked
  assign en       = !item_valid || take;
  assign in_ready = en;

  ssd_digit_pipe u_pipe (
    .clk          (clk),
    .rst_n        (rst_n),
    .en           (en),
    .in_valid     (in_valid),
    .in_operation (in_operation),
    .in_value     (in_value),
    .in_separator (in_separator),
    .item_valid   (item_valid),
    .item         (item)
  );

  ssd_frame_ser u_ser (
    .clk              (clk),
    .rst_n            (rst_n),
    .item_valid       (item_valid),
    .item             (item),
    .take             (take),
    .brightness       (brightness_r),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_frame_byte   (out_frame_byte),
    .out_start_before (out_start_before),
    .out_stop_after   (out_stop_after),
    .out_last         (out_last)
  );

endmodule

`default_nettype wire

// ----- tb/tb_seven_segment_display_frame_builder_core.sv -----
// testbench for seven_segment_display_frame_builder_core: drives show and brightness
// requests, predicts the framed display bytes and checks every output word in order
// depends on ssd_pkg and the core module only
`timescale 1ns / 100ps

module tb_seven_segment_display_frame_builder_core;

  typedef struct packed {
    logic        op;
    logic [15:0] value;
    logic        sep;
  } request_t;

  typedef struct packed {
    logic [7:0] data;
    logic       start_before;
    logic       stop_after;
    logic       last;
  } frame_t;

  localparam logic [7:0] DIGIT_SEGS [10] = '{
    8'h3f, 8'h06, 8'h5b, 8'h4f, 8'h66, 8'h6d, 8'h7d, 8'h07, 8'h7f, 8'h6f
  };
  localparam int HOLD_CYCLES = 400;
  localparam int SETTLE_CYCLES = 20;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic        in_operation = ssd_pkg::OP_SHOW;
  logic [15:0] in_value = '0;
  logic        in_separator = 1'b0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [7:0]  out_frame_byte;
  logic        out_start_before;
  logic        out_stop_after;
  logic        out_last;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [3:0]  cfg_brightness = '0;

  request_t    pending_reqs[$];
  frame_t      expected_frames[$];
  logic [3:0]  brightness_shadow = ssd_pkg::BRIGHT_RESET;
  logic        in_taken = 1'b0;
  logic        hold_request = 1'b0;
  logic        recv_hold = 1'b0;
  int unsigned send_idle_pct = 0;
  int unsigned recv_stall_pct = 0;
  int          errors = 0;

  seven_segment_display_frame_builder_core uut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_operation     (in_operation),
    .in_value         (in_value),
    .in_separator     (in_separator),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_frame_byte   (out_frame_byte),
    .out_start_before (out_start_before),
    .out_stop_after   (out_stop_after),
    .out_last         (out_last),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_brightness   (cfg_brightness)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  // expected byte sequence for one accepted request
  task automatic predict_frames(input request_t r);
    logic [3:0] level;
    logic [7:0] hund;
    int unsigned v;
    v = r.value;
    if (r.op == ssd_pkg::OP_BRIGHT) begin
      level = (brightness_shadow > ssd_pkg::BRIGHT_MAX) ? ssd_pkg::BRIGHT_MAX
                                                         : brightness_shadow;
      expected_frames.push_back('{ssd_pkg::CMD_BRIGHT + {4'b0000, level},
                                  1'b1, 1'b1, 1'b1});
    end else begin
      hund = DIGIT_SEGS[(v / 100) % 10];
      if (r.sep) hund = hund | ssd_pkg::SEP_BIT;
      expected_frames.push_back('{ssd_pkg::CMD_DATA, 1'b1, 1'b1, 1'b0});
      expected_frames.push_back('{ssd_pkg::CMD_ADDR, 1'b1, 1'b0, 1'b0});
      expected_frames.push_back('{DIGIT_SEGS[(v / 1000) % 10], 1'b0, 1'b0, 1'b0});
      expected_frames.push_back('{hund, 1'b0, 1'b0, 1'b0});
      expected_frames.push_back('{DIGIT_SEGS[(v / 10) % 10], 1'b0, 1'b0, 1'b0});
      expected_frames.push_back('{DIGIT_SEGS[v % 10], 1'b0, 1'b1, 1'b1});
    end
  endtask

  // request driver
  always @(negedge clk) begin : drive_requests
    request_t r;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_taken) begin
      if (pending_reqs.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
        r = pending_reqs.pop_front();
        in_valid     <= 1'b1;
        in_operation <= r.op;
        in_value     <= r.value;
        in_separator <= r.sep;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  always @(negedge clk) begin
    if (!rst_n || recv_hold) begin
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // long receiver hold-off so the pipeline backs up into the input
  initial begin
    wait (hold_request);
    @(negedge clk);
    recv_hold <= 1'b1;
    repeat (HOLD_CYCLES) @(negedge clk);
    recv_hold <= 1'b0;
  end

  always @(posedge clk) begin : track_inputs
    request_t r;
    in_taken <= rst_n && in_valid && in_ready;
    if (rst_n && in_valid && in_ready) begin
      r = '{in_operation, in_value, in_separator};
      predict_frames(r);
    end
    if (rst_n && cfg_valid && cfg_ready) brightness_shadow <= cfg_brightness;
  end

  always @(posedge clk) begin : check_frames
    frame_t want;
    frame_t got;
    if (rst_n && out_valid && out_ready) begin
      got = '{out_frame_byte, out_start_before, out_stop_after, out_last};
      if (expected_frames.size() == 0) begin
        errors++;
        $display("%0t: unexpected word byte=%h start=%b stop=%b last=%b", $time,
                 got.data, got.start_before, got.stop_after, got.last);
      end else begin
        want = expected_frames.pop_front();
        if (got !== want) begin
          errors++;
          $display("%0t: mismatch expected %h/%b/%b/%b got %h/%b/%b/%b",
                   $time, want.data, want.start_before, want.stop_after, want.last,
                   got.data, got.start_before, got.stop_after, got.last);
        end
      end
    end
  end

  task automatic queue_request(input logic op, input logic [15:0] value, input logic sep);
    pending_reqs.push_back('{op, value, sep});
  endtask

  // wait for every queued request and expected word, then let the pipeline settle
  task automatic drain();
    @(posedge clk);
    while (pending_reqs.size() != 0 || in_valid || expected_frames.size() != 0)
      @(posedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_brightness(input logic [3:0] level);
    @(negedge clk);
    cfg_valid      <= 1'b1;
    cfg_brightness <= level;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  initial begin : main_sequence
    int unsigned send_rates [4];
    int unsigned stall_rates [4];
    logic [3:0] phase_levels [4];
    logic [15:0] v;
    logic op;
    int mode;
    send_rates  = '{0, 85, 0, 20};
    stall_rates = '{0, 0, 85, 20};
    phase_levels = '{4'd0, 4'd15, 4'd1, 4'd9};

    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // directed: digit extremes, dropped fifth digit, separator, reset brightness
    queue_request(ssd_pkg::OP_BRIGHT, 16'h0000, 1'b0);
    queue_request(ssd_pkg::OP_SHOW, 16'd0, 1'b0);
    queue_request(ssd_pkg::OP_SHOW, 16'd65535, 1'b1);
    queue_request(ssd_pkg::OP_SHOW, 16'd9999, 1'b0);
    queue_request(ssd_pkg::OP_SHOW, 16'd10000, 1'b1);
    queue_request(ssd_pkg::OP_SHOW, 16'd12345, 1'b0);
    queue_request(ssd_pkg::OP_SHOW, 16'd1234, 1'b1);
    queue_request(ssd_pkg::OP_SHOW, 16'd5678, 1'b0);
    queue_request(ssd_pkg::OP_SHOW, 16'd9012, 1'b1);
    queue_request(ssd_pkg::OP_SHOW, 16'd8888, 1'b1);
    queue_request(ssd_pkg::OP_SHOW, 16'd100, 1'b1);
    queue_request(ssd_pkg::OP_SHOW, 16'd7, 1'b0);
    queue_request(ssd_pkg::OP_SHOW, 16'd40000, 1'b0);
    queue_request(ssd_pkg::OP_BRIGHT, 16'hffff, 1'b1);
    drain();
    // brightness saturation and the off setting
    write_brightness(4'd15);
    queue_request(ssd_pkg::OP_BRIGHT, 16'd0, 1'b0);
    queue_request(ssd_pkg::OP_SHOW, 16'd30507, 1'b1);
    drain();
    write_brightness(4'd0);
    queue_request(ssd_pkg::OP_BRIGHT, 16'd0, 1'b0);
    drain();
    write_brightness(4'd9);
    queue_request(ssd_pkg::OP_BRIGHT, 16'd0, 1'b0);
    drain();
    write_brightness(4'd8);
    queue_request(ssd_pkg::OP_BRIGHT, 16'd0, 1'b0);
    drain();

    for (int p = 0; p < 4; p++) begin
      send_idle_pct  = send_rates[p];
      recv_stall_pct = stall_rates[p];
      if (p == 0) hold_request = 1'b1;
      for (int half = 0; half < 2; half++) begin
        write_brightness(half == 0 ? phase_levels[p] : 4'($urandom_range(15)));
        for (int i = 0; i < 26; i++) begin
          op = ($urandom_range(99) < 30) ? ssd_pkg::OP_BRIGHT : ssd_pkg::OP_SHOW;
          mode = $urandom_range(3);
          case (mode)
            0:       v = 16'($urandom_range(65535));
            1:       v = 16'($urandom_range(9999));
            2:       v = 16'($urandom_range(99));
            default: v = 16'($urandom_range(65535, 10000));
          endcase
          queue_request(op, v, 1'($urandom_range(1)));
        end
        // sender pauses here until every word has come back
        drain();
      end
    end

    if (errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  initial begin
    #400000;
    $display("tb: failure");
    $finish;
  end

endmodule
